/* rtl/rpp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers of the pinhole projection core.
// No dependencies; imported by rpp_div and rigid_pinhole_projection_core.
package rpp_pkg;

    localparam int NUM_W    = 64;
    localparam int DEN_W    = 32;
    localparam int QUO_W    = 34;
    localparam int HI_W     = NUM_W - QUO_W;
    localparam int ROT_W    = 20;
    localparam int ROT_FRAC = 18;
    localparam int ADDR_W   = 6;
    localparam int STAGES   = 44;

    typedef enum logic [2:0] {
        REG_FOCAL    = 3'd0,
        REG_CENTER   = 3'd1,
        REG_ROT0     = 3'd2,
        REG_ROT1     = 3'd3,
        REG_ROT2     = 3'd4,
        REG_SHIFT_XY = 3'd5,
        REG_SHIFT_Z  = 3'd6
    } t_reg;

    typedef struct packed {
        logic        op;
        logic        bad;
        logic [31:0] kc;
        logic        neg_x;
        logic        neg_y;
    } t_side;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [37:0] rot_round(input logic signed [55:0] x);
        logic signed [55:0] t;
        t = x + 56'sd131072;
        return t[55:ROT_FRAC];
    endfunction

endpackage

/* rtl/rigid_pinhole_projection_core.sv */
`timescale 1ns / 1ps
// Rigid transform and pinhole projection / back-projection pipeline.
// Depends on rpp_pkg and rpp_div.
//
//  port group | direction | handshake        | payload
//  input word | in        | i_valid/o_stall  | i_op, i_in_a, i_in_b, i_in_c
//  result word| out       | o_valid/i_stall  | o_out_a, o_out_b, o_out_c, o_bad_divisor
//  config     | in        | psel/penable     | paddr, pwdata, prdata
//
// One word per cycle unless stalled; includes the 34-step divider pipeline.
// Synchronous active-low reset clears valid bits and configuration registers.
// A stalled result word stalls the whole pipeline; nothing is dropped.
module rigid_pinhole_projection_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  logic signed [31:0]           i_in_a,
    input  logic signed [31:0]           i_in_b,
    input  logic signed [31:0]           i_in_c,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [31:0]           o_out_a,
    output logic signed [31:0]           o_out_b,
    output logic signed [31:0]           o_out_c,
    output logic                         o_bad_divisor,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpp_pkg::ADDR_W-1:0]   paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);
    import rpp_pkg::*;

    logic [63:0] r_focal;
    logic [63:0] r_center;
    logic [59:0] r_rot [3];
    logic [63:0] r_shift_xy;
    logic [31:0] r_shift_z;
    t_reg        w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg'(paddr[ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal    <= '0;
            r_center   <= '0;
            r_rot[0]   <= '0;
            r_rot[1]   <= '0;
            r_rot[2]   <= '0;
            r_shift_xy <= '0;
            r_shift_z  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_FOCAL:    r_focal    <= pwdata;
                REG_CENTER:   r_center   <= pwdata;
                REG_ROT0:     r_rot[0]   <= pwdata[59:0];
                REG_ROT1:     r_rot[1]   <= pwdata[59:0];
                REG_ROT2:     r_rot[2]   <= pwdata[59:0];
                REG_SHIFT_XY: r_shift_xy <= pwdata;
                REG_SHIFT_Z:  r_shift_z  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FOCAL:    prdata = r_focal;
            REG_CENTER:   prdata = r_center;
            REG_ROT0:     prdata = {4'd0, r_rot[0]};
            REG_ROT1:     prdata = {4'd0, r_rot[1]};
            REG_ROT2:     prdata = {4'd0, r_rot[2]};
            REG_SHIFT_XY: prdata = r_shift_xy;
            REG_SHIFT_Z:  prdata = {32'd0, r_shift_z};
            default:      prdata = '0;
        endcase
    end

    logic [31:0]        w_fx, w_fy, w_cx, w_cy;
    logic signed [31:0] w_t [3];
    logic signed [ROT_W-1:0] w_rot [3][3];

    assign w_fx   = r_focal[63:32];
    assign w_fy   = r_focal[31:0];
    assign w_cx   = r_center[63:32];
    assign w_cy   = r_center[31:0];
    assign w_t[0] = r_shift_xy[63:32];
    assign w_t[1] = r_shift_xy[31:0];
    assign w_t[2] = r_shift_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_rot[i][j] = r_rot[i][59-ROT_W*j -: ROT_W];
            end
        end
    end

    // pipeline control
    logic [STAGES-1:0] r_vld;
    logic              w_adv;

    assign w_adv   = !(r_vld[STAGES-1] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    // front stages
    logic               r1_op;
    logic signed [31:0] r1_a, r1_b, r1_c;
    logic               r2_op;
    logic signed [51:0] r2_m [3][3];
    logic signed [31:0] r2_dx, r2_dy, r2_c;
    logic               r3_op;
    logic signed [37:0] r3_s [3];
    logic signed [31:0] r3_dx, r3_dy, r3_c;
    logic               r4_op;
    logic signed [31:0] r4_pc [3];
    logic               r5_op, r5_bad;
    logic signed [64:0] r5_n0, r5_n1;
    logic signed [31:0] r5_pc2;

    logic signed [31:0] w_p1 [3];
    logic signed [37:0] w_s3 [3];
    logic signed [31:0] w_pc4 [3];
    logic signed [32:0] w_k0, w_k1;

    assign w_p1[0] = r1_a;
    assign w_p1[1] = r1_b;
    assign w_p1[2] = r1_c;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s3[i]  = rot_round(56'(r2_m[i][0]) + 56'(r2_m[i][1]) + 56'(r2_m[i][2]));
            w_pc4[i] = sat32(40'(r3_s[i]) + 40'(w_t[i]));
        end
    end

    assign w_k0 = r4_op ? 33'(r4_pc[2]) : $signed({1'b0, w_fx});
    assign w_k1 = r4_op ? 33'(r4_pc[2]) : $signed({1'b0, w_fy});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_op <= i_op;
            r1_a  <= i_in_a;
            r1_b  <= i_in_b;
            r1_c  <= i_in_c;

            r2_op <= r1_op;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r2_m[i][j] <= w_rot[i][j] * w_p1[j];
                end
            end
            r2_dx <= sat32(40'(r1_a) - $signed({8'd0, w_cx}));
            r2_dy <= sat32(40'(r1_b) - $signed({8'd0, w_cy}));
            r2_c  <= r1_c;

            r3_op <= r2_op;
            r3_s  <= w_s3;
            r3_dx <= r2_dx;
            r3_dy <= r2_dy;
            r3_c  <= r2_c;

            r4_op    <= r3_op;
            r4_pc[0] <= r3_op ? r3_dx : w_pc4[0];
            r4_pc[1] <= r3_op ? r3_dy : w_pc4[1];
            r4_pc[2] <= r3_op ? r3_c  : w_pc4[2];

            r5_op  <= r4_op;
            r5_bad <= (r4_pc[2] <= 32'sd0) || (w_fx == '0) || (w_fy == '0);
            r5_n0  <= w_k0 * r4_pc[0];
            r5_n1  <= w_k1 * r4_pc[1];
            r5_pc2 <= r4_pc[2];
        end
    end

    // divide
    logic signed [64:0] w_neg_n0, w_neg_n1;
    logic [31:0]        w_neg_z, w_abs_z;
    logic [NUM_W-1:0]   w_mn0, w_mn1;
    logic [DEN_W-1:0]   w_md0, w_md1;
    t_side              w_side;
    t_side              r_side [QUO_W+1];
    logic [QUO_W-1:0]   w_qx, w_qy;
    logic               w_ovx, w_ovy;

    assign w_neg_n0 = -r5_n0;
    assign w_neg_n1 = -r5_n1;
    assign w_neg_z  = -r5_pc2;
    assign w_abs_z  = r5_pc2[31] ? w_neg_z : r5_pc2;
    assign w_mn0    = r5_n0[64] ? w_neg_n0[63:0] : r5_n0[63:0];
    assign w_mn1    = r5_n1[64] ? w_neg_n1[63:0] : r5_n1[63:0];
    assign w_md0    = r5_op ? w_fx : w_abs_z;
    assign w_md1    = r5_op ? w_fy : w_abs_z;

    always_comb begin
        w_side.op    = r5_op;
        w_side.bad   = r5_bad;
        w_side.kc    = r5_pc2;
        w_side.neg_x = r5_n0[64] ^ (!r5_op && r5_pc2[31]);
        w_side.neg_y = r5_n1[64] ^ (!r5_op && r5_pc2[31]);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= w_side;
            for (int k = 1; k <= QUO_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    rpp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (w_mn0),
        .i_den (w_md0),
        .o_quo (w_qx),
        .o_ovf (w_ovx)
    );

    rpp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (w_mn1),
        .i_den (w_md1),
        .o_quo (w_qy),
        .o_ovf (w_ovy)
    );

    // back stages
    t_side              w_sd;
    logic signed [34:0] w_qsx, w_qsy;
    logic signed [31:0] w_satx, w_saty, w_px, w_py, w_bx, w_by;
    logic signed [32:0] w_e [3];

    assign w_sd   = r_side[QUO_W];
    assign w_qsx  = w_sd.neg_x ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
    assign w_qsy  = w_sd.neg_y ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});
    assign w_satx = w_sd.neg_x ? 32'sh80000000 : 32'sh7fffffff;
    assign w_saty = w_sd.neg_y ? 32'sh80000000 : 32'sh7fffffff;
    assign w_px   = w_ovx ? w_satx : sat32(40'(w_qsx) + $signed({8'd0, w_cx}));
    assign w_py   = w_ovy ? w_saty : sat32(40'(w_qsy) + $signed({8'd0, w_cy}));
    assign w_bx   = w_ovx ? w_satx : sat32(40'(w_qsx));
    assign w_by   = w_ovy ? w_saty : sat32(40'(w_qsy));
    assign w_e[0] = w_sd.op ? 33'(w_bx) - 33'(w_t[0]) : 33'(w_px);
    assign w_e[1] = w_sd.op ? 33'(w_by) - 33'(w_t[1]) : 33'(w_py);
    assign w_e[2] = w_sd.op ? 33'($signed(w_sd.kc)) - 33'(w_t[2])
                            : 33'($signed(w_sd.kc));

    logic               rq1_op, rq1_bad;
    logic signed [32:0] rq1_e [3];
    logic               rq2_op, rq2_bad;
    logic signed [52:0] rq2_m [3][3];
    logic signed [31:0] rq2_k [3];
    logic               rq3_op, rq3_bad;
    logic signed [37:0] rq3_s [3];
    logic signed [31:0] rq3_k [3];
    logic signed [37:0] w_ws [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ws[i] = rot_round(56'(rq2_m[i][0]) + 56'(rq2_m[i][1]) + 56'(rq2_m[i][2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rq1_op  <= w_sd.op;
            rq1_bad <= w_sd.bad;
            rq1_e   <= w_e;

            rq2_op  <= rq1_op;
            rq2_bad <= rq1_bad;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    rq2_m[i][j] <= w_rot[j][i] * rq1_e[j];
                end
                rq2_k[i] <= rq1_e[i][31:0];
            end

            rq3_op  <= rq2_op;
            rq3_bad <= rq2_bad;
            rq3_s   <= w_ws;
            rq3_k   <= rq2_k;

            o_out_a       <= rq3_op ? sat32(40'(rq3_s[0])) : rq3_k[0];
            o_out_b       <= rq3_op ? sat32(40'(rq3_s[1])) : rq3_k[1];
            o_out_c       <= rq3_op ? sat32(40'(rq3_s[2])) : rq3_k[2];
            o_bad_divisor <= rq3_bad;
        end
    end

endmodule

/* rtl/rpp_div.sv */
`timescale 1ns / 1ps
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on rpp_pkg for widths.
module rpp_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rpp_pkg::NUM_W-1:0]   i_num,
    input  logic [rpp_pkg::DEN_W-1:0]   i_den,
    output logic [rpp_pkg::QUO_W-1:0]   o_quo,
    output logic                        o_ovf
);
    import rpp_pkg::*;

    logic [DEN_W-1:0] r_rem [QUO_W+1];
    logic [QUO_W-1:0] r_low [QUO_W+1];
    logic [DEN_W-1:0] r_den [QUO_W+1];
    logic             r_ovf [QUO_W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DEN_W'(i_num[NUM_W-1:QUO_W]);
            r_low[0] <= i_num[QUO_W-1:0];
            r_den[0] <= i_den;
            r_ovf[0] <= DEN_W'(i_num[NUM_W-1:QUO_W]) >= i_den;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DEN_W:0] w_cand;
        logic [DEN_W:0] w_diff;
        logic           w_ge;
        assign w_cand = {r_rem[k-1], r_low[k-1][QUO_W-1]};
        assign w_diff = w_cand - {1'b0, r_den[k-1]};
        assign w_ge   = w_cand >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[DEN_W-1:0] : w_cand[DEN_W-1:0];
                r_low[k] <= {r_low[k-1][QUO_W-2:0], w_ge};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_low[QUO_W];
    assign o_ovf = r_ovf[QUO_W];

endmodule
